>>> hw/rtl/mfmtse_pkg.sv
// Shared types and constants for the MFM track sector extractor.
package mfmtse_pkg;

	// Parse modes
	localparam logic [1:0] MODE_HUNT_ID    = 2'd0;
	localparam logic [1:0] MODE_CAPTURE_ID = 2'd1;
	localparam logic [1:0] MODE_HUNT_DATA  = 2'd2;
	localparam logic [1:0] MODE_COPY       = 2'd3;

	// ID mark: 00 00 00 00 A1 A1 A1 FE, newest byte in the low byte
	localparam logic [63:0] ID_MARK_WORD   = 64'h0000_0000_A1A1_A1FE;
	localparam logic [31:0] DATA_MARK_WORD = 32'hA1A1_A1FB;
	localparam logic [63:0] WINDOW_FILL    = '1;
	localparam logic [10:0] BASE_SECTOR_LEN = 11'd128;

	localparam int unsigned IN_TDATA_W  = 8;
	localparam int unsigned OUT_TDATA_W = 40;

	typedef struct packed {
		logic [7:0] data_byte;
		logic [7:0] cylinder;
		logic [7:0] head_number;
		logic [7:0] sector_number;
		logic [1:0] size_code;
		logic       last_of_sector;
		logic       truncated;
	} result_t;

endpackage

>>> hw/rtl/mfm_track_sector_extractor_unit.sv
// Top level: MFM track sector deframer with a two-word result buffer.
//
// Usage:
//   Slave side (s_tvalid/s_tready/s_tdata/s_tlast) takes one decoded track
//   byte per word; s_tlast marks the last byte of a track. The block hunts for
//   an ID address mark, captures cylinder/head/sector/size, hunts for the data
//   address mark and then forwards the 128 << size data bytes on the master
//   side (m_tvalid/m_tready/m_tdata/m_tlast/m_tuser), each tagged with the ID
//   fields. m_tlast flags the final byte of a sector; m_tuser flags a sector
//   cut short by the end of the track.
//   Output: an accepted data byte is registered in the output register, or in
//   the skid register while the output register holds a result and m_tready is low.
//   Throughput: one word per cycle while s_tready is high; the parse step for a
//   byte is combinational (a 64-bit or 32-bit mark compare, an ID byte capture or a decrement).
//   Stall: results queue in an output register plus a skid register, so the
//   slave side keeps taking words while one result waits; s_tready drops only
//   while both hold a result.
//   Reset: arst_n clears both buffers and returns the parser to hunting for an
//   ID mark with the byte window filled with FF. The word that carries s_tlast
//   returns the parser to that hunting state once processed; it does not clear the buffers.
module mfm_track_sector_extractor_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [mfmtse_pkg::IN_TDATA_W-1:0]   s_tdata,  // [7:0] track_byte
	input  logic                                s_tlast,  // track_end
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// [7:0] data_byte, [15:8] cylinder, [23:16] head_number,
	// [31:24] sector_number, [33:32] size_code, [39:34] zero
	output logic [mfmtse_pkg::OUT_TDATA_W-1:0]  m_tdata,
	output logic                                m_tlast,  // last_of_sector
	output logic [0:0]                          m_tuser   // [0] truncated
);

	// Parser state
	logic [63:0] win_q, win_d;
	logic [1:0]  mode_q, mode_d;
	logic [7:0]  cyl_q, cyl_d;
	logic [7:0]  head_q, head_d;
	logic [7:0]  sect_q, sect_d;
	logic [1:0]  size_q, size_d;
	logic [1:0]  cnt_q, cnt_d;
	logic [10:0] rem_q, rem_d;

	// Result buffer
	logic                  out_valid_q, out_valid_d;
	logic                  skid_valid_q, skid_valid_d;
	mfmtse_pkg::result_t   out_q, out_d;
	mfmtse_pkg::result_t   skid_q, skid_d;

	logic                  in_fire;
	logic                  res_valid;
	mfmtse_pkg::result_t   res;
	logic [63:0]           win_shift;
	logic [10:0]           rem_dec;
	logic [7:0]            in_byte;
	logic                  out_load;

	assign in_byte  = s_tdata[7:0];
	assign s_tready = !skid_valid_q;
	assign in_fire  = s_tvalid && s_tready;

	assign win_shift = {win_q[55:0], in_byte};
	assign rem_dec   = rem_q - 11'd1;

	always_comb begin
		win_d     = win_q;
		mode_d    = mode_q;
		cyl_d     = cyl_q;
		head_d    = head_q;
		sect_d    = sect_q;
		size_d    = size_q;
		cnt_d     = cnt_q;
		rem_d     = rem_q;
		res_valid = 1'b0;
		res       = '0;
		case (mode_q)
			mfmtse_pkg::MODE_COPY: begin
				rem_d              = rem_dec;
				res_valid          = 1'b1;
				res.data_byte      = in_byte;
				res.cylinder       = cyl_q;
				res.head_number    = head_q;
				res.sector_number  = sect_q;
				res.size_code      = size_q;
				res.last_of_sector = (rem_dec == 11'd0) || s_tlast;
				res.truncated      = (rem_dec != 11'd0) && s_tlast;
				if (rem_dec == 11'd0) begin
					mode_d = mfmtse_pkg::MODE_HUNT_ID;
					win_d  = mfmtse_pkg::WINDOW_FILL;
				end
			end
			mfmtse_pkg::MODE_HUNT_ID: begin
				win_d = win_shift;
				if (win_shift == mfmtse_pkg::ID_MARK_WORD) begin
					mode_d = mfmtse_pkg::MODE_CAPTURE_ID;
					cnt_d  = 2'd0;
					cyl_d  = 8'd0;
					head_d = 8'd0;
					sect_d = 8'd0;
					size_d = 2'd0;
				end
			end
			mfmtse_pkg::MODE_CAPTURE_ID: begin
				win_d = win_shift;
				cnt_d = cnt_q + 2'd1;
				case (cnt_q)
					2'd0: cyl_d  = in_byte;
					2'd1: head_d = in_byte;
					2'd2: sect_d = in_byte;
					default: begin
						size_d = in_byte[1:0];
						mode_d = mfmtse_pkg::MODE_HUNT_DATA;
						// the ID bytes themselves may form the data mark
						if (win_shift[31:0] == mfmtse_pkg::DATA_MARK_WORD) begin
							mode_d = mfmtse_pkg::MODE_COPY;
							rem_d  = mfmtse_pkg::BASE_SECTOR_LEN << in_byte[1:0];
						end
					end
				endcase
			end
			default: begin
				win_d = win_shift;
				if (win_shift[31:0] == mfmtse_pkg::DATA_MARK_WORD) begin
					mode_d = mfmtse_pkg::MODE_COPY;
					rem_d  = mfmtse_pkg::BASE_SECTOR_LEN << size_q;
				end
			end
		endcase
		// track end: back to hunting with everything cleared
		if (s_tlast) begin
			win_d  = mfmtse_pkg::WINDOW_FILL;
			mode_d = mfmtse_pkg::MODE_HUNT_ID;
			cyl_d  = 8'd0;
			head_d = 8'd0;
			sect_d = 8'd0;
			size_d = 2'd0;
			cnt_d  = 2'd0;
			rem_d  = 11'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q  <= mfmtse_pkg::WINDOW_FILL;
			mode_q <= mfmtse_pkg::MODE_HUNT_ID;
			cyl_q  <= 8'd0;
			head_q <= 8'd0;
			sect_q <= 8'd0;
			size_q <= 2'd0;
			cnt_q  <= 2'd0;
			rem_q  <= 11'd0;
		end else if (in_fire) begin
			win_q  <= win_d;
			mode_q <= mode_d;
			cyl_q  <= cyl_d;
			head_q <= head_d;
			sect_q <= sect_d;
			size_q <= size_d;
			cnt_q  <= cnt_d;
			rem_q  <= rem_d;
		end
	end

	// Output register refills from the skid first, then from the new word
	assign out_load = !out_valid_q || m_tready;

	always_comb begin
		out_valid_d  = out_valid_q;
		skid_valid_d = skid_valid_q;
		out_d        = out_q;
		skid_d       = skid_q;
		if (out_load) begin
			if (skid_valid_q) begin
				out_d        = skid_q;
				out_valid_d  = 1'b1;
				skid_valid_d = 1'b0;
			end else begin
				out_d       = res;
				out_valid_d = in_fire && res_valid;
			end
		end else if (in_fire && res_valid) begin
			skid_d       = res;
			skid_valid_d = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			out_valid_q  <= out_valid_d;
			skid_valid_q <= skid_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		out_q  <= out_d;
		skid_q <= skid_d;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'd0, out_q.size_code, out_q.sector_number, out_q.head_number,
		out_q.cylinder, out_q.data_byte};
	assign m_tlast  = out_q.last_of_sector;
	assign m_tuser  = out_q.truncated;

`ifndef NO_ASSERTIONS
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid holds a word while the output register is empty");

	a_trunc_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.truncated) |-> out_q.last_of_sector)
		else $error("truncated word not flagged as last of sector");

	a_copy_count: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == mfmtse_pkg::MODE_COPY) |-> (rem_q != 11'd0))
		else $error("copy mode with no bytes left");

	a_track_end_reset: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && s_tlast) |=>
		(mode_q == mfmtse_pkg::MODE_HUNT_ID && win_q == mfmtse_pkg::WINDOW_FILL))
		else $error("track end did not return the parser to hunting");
`endif

endmodule
